@@ src/shs_pkg.sv @@
`default_nettype none
package shs_pkg;

   localparam int unsigned WordBits  = 64;
   localparam int unsigned BlockWords = 16;
   localparam int unsigned Rounds    = 80;
   localparam int unsigned FifoDepth = 4;

   typedef logic [63:0] word_type;

   // One entry of the queue between the front and the back: a schedule word,
   // with a mark for the final padded block of a message.
   typedef struct packed {
      word_type word;
      logic     msg_end;
   } item_type;

   localparam word_type InitHash [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
      64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam word_type RoundK [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (WordBits - n));
   endfunction

endpackage
`default_nettype wire

@@ src/shs_front.sv @@
`default_nettype none
// Packs message words, counts the length and generates the padding words.
module shs_front import shs_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_push,
   output logic           req_full,
   input  wire word_type  req_data_word,
   input  wire logic [3:0] req_byte_count,
   input  wire logic      req_last_word,
   output logic           q_push,
   input  wire logic      q_full,
   output item_type       q_item
);

   typedef enum logic [3:0] {
      ST_TAKE  = 4'b0001,
      ST_PAD80 = 4'b0010,
      ST_ZERO  = 4'b0100,
      ST_LEN   = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   logic [3:0]   fill_ff, fill_in;
   logic [127:0] len_ff, len_in;
   logic         len_lo_ff, len_lo_in;   // high length word sent, low word next

   logic [3:0]   cnt;
   word_type     keep, packed_word;

   always_comb begin
      cnt  = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
      keep = (cnt == 4'd0) ? '0 : ~({64{1'b1}} >> {cnt, 3'b000});
      packed_word = (req_data_word & keep) | (64'h80 << (7'd56 - {cnt[2:0], 3'b000}));
   end

   assign req_full = (state_ff != ST_TAKE) || q_full;

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      len_in    = len_ff;
      len_lo_in = len_lo_ff;
      q_push    = 1'b0;
      q_item    = '{word: '0, msg_end: 1'b0};
      case (state_ff)
         ST_TAKE: begin
            if (req_push && !q_full) begin
               q_push = 1'b1;
               if (!req_last_word) begin
                  q_item.word = req_data_word;
                  len_in = len_ff + 128'd64;
               end else begin
                  len_in = len_ff + {121'd0, cnt, 3'b000};
                  if (cnt == 4'd8) begin
                     q_item.word = req_data_word;
                     state_in = ST_PAD80;
                  end else begin
                     q_item.word = packed_word;
                     state_in = (fill_ff == 4'd13) ? ST_LEN :
                                ST_ZERO;
                  end
               end
               fill_in = fill_ff + 4'd1;
            end
         end
         ST_PAD80: begin
            if (!q_full) begin
               q_push = 1'b1;
               q_item.word = 64'h8000000000000000;
               fill_in = fill_ff + 4'd1;
               state_in = (fill_ff == 4'd13) ? ST_LEN : ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (!q_full) begin
               q_push = 1'b1;
               fill_in = fill_ff + 4'd1;
               if (fill_ff == 4'd13) state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (!q_full) begin
               q_push = 1'b1;
               fill_in = fill_ff + 4'd1;
               if (!len_lo_ff) begin
                  q_item.word = len_ff[127:64];
                  len_lo_in = 1'b1;
               end else begin
                  q_item.word = len_ff[63:0];
                  q_item.msg_end = 1'b1;
                  len_lo_in = 1'b0;
                  len_in = '0;
                  state_in = ST_TAKE;
               end
            end
         end
         default: state_in = ST_TAKE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_TAKE;
         fill_ff   <= '0;
         len_ff    <= '0;
         len_lo_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         len_ff    <= len_in;
         len_lo_ff <= len_lo_in;
      end
   end

   // The length words always land in the last two slots of a block.
   assert property (@(posedge clock) disable iff (reset)
      (q_push && q_item.msg_end) |-> (fill_ff == 4'd15))
      else $error("length word misplaced");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN && len_lo_ff) |-> (fill_ff == 4'd15))
      else $error("low length word out of place");
   assert property (@(posedge clock) disable iff (reset)
      (q_push && q_item.msg_end) |=> (fill_ff == 4'd0 && len_ff == '0))
      else $error("message state not cleared");

endmodule
`default_nettype wire

@@ src/shs_queue.sv @@
`default_nettype none
// Short queue between the front and the back.
module shs_queue import shs_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output logic          empty,
   output item_type      head
);

   localparam int unsigned Aw = $clog2(FifoDepth);

   item_type       mem_ff [FifoDepth];
   logic [Aw-1:0]  wp_ff, rp_ff;
   logic [Aw:0]    cnt_ff, cnt_in;

   assign full  = (cnt_ff == (Aw+1)'(FifoDepth));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + (Aw+1)'(push && !full) - (Aw+1)'(pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wp_ff] <= push_item;
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push && !full) wp_ff <= wp_ff + 1'b1;
         if (pop && !empty) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (Aw+1)'(FifoDepth)) else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || cnt_ff == (Aw+1)'(FifoDepth)) |-> (wp_ff == rp_ff))
      else $error("queue pointers inconsistent");
   assert property (@(posedge clock) disable iff (reset)
      (push && !full && !(pop && !empty)) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count lost a beat");

endmodule
`default_nettype wire

@@ src/shs_back.sv @@
`default_nettype none
// Loads sixteen schedule words, runs 80 rounds, updates the chaining state
// and, at the end of a message, hands out the eight digest words.
module shs_back import shs_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_empty,
   input  wire item_type q_head,
   output logic          q_pop,
   output logic          rsp_empty,
   input  wire logic     rsp_pop,
   output word_type      rsp_digest_word,
   output logic          rsp_digest_last
);

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_ADD   = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   word_type    w_ff [16];
   word_type    v_ff [8];
   word_type    h_ff [8];
   logic [3:0]  ld_ff, ld_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic [2:0]  oi_ff, oi_in;
   logic        end_ff, end_in;

   word_type wt, w2, w15, s0, s1, t1, t2;

   always_comb begin
      w2  = w_ff[14];
      w15 = w_ff[1];
      s1  = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
      s0  = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
      wt  = (rnd_ff < 7'd16) ? w_ff[0] : (s1 + w_ff[9] + s0 + w_ff[0]);
      t1  = v_ff[7] + (rotr(v_ff[4], 14) ^ rotr(v_ff[4], 18) ^ rotr(v_ff[4], 41))
            + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + RoundK[rnd_ff] + wt;
      t2  = (rotr(v_ff[0], 28) ^ rotr(v_ff[0], 34) ^ rotr(v_ff[0], 39))
            + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   assign q_pop           = (state_ff == ST_LOAD) && !q_empty;
   assign rsp_empty       = (state_ff != ST_OUT);
   assign rsp_digest_word = h_ff[0];
   assign rsp_digest_last = (oi_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      ld_in    = ld_ff;
      rnd_in   = rnd_ff;
      oi_in    = oi_ff;
      end_in   = end_ff;
      case (state_ff)
         ST_LOAD: begin
            if (!q_empty) begin
               ld_in = ld_ff + 4'd1;
               if (ld_ff == 4'd15) begin
                  end_in   = q_head.msg_end;
                  rnd_in   = '0;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'(Rounds - 1)) state_in = ST_ADD;
         end
         ST_ADD: begin
            oi_in    = '0;
            state_in = end_ff ? ST_OUT : ST_LOAD;
         end
         ST_OUT: begin
            if (rsp_pop) begin
               oi_in = oi_ff + 3'd1;
               if (oi_ff == 3'd7) state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      // The buffer shifts one word per load beat and per round; the bottom holds
      // the current word for rounds 0..15 and the word sixteen back after that.
      if ((state_ff == ST_LOAD && !q_empty) || state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= (state_ff == ST_LOAD) ? q_head.word : wt;
      end
      if (state_ff == ST_LOAD && !q_empty && ld_ff == 4'd15) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (state_ff == ST_ROUND) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
      if (reset) begin
         state_ff <= ST_LOAD;
         ld_ff    <= '0;
         rnd_ff   <= '0;
         oi_ff    <= '0;
         end_ff   <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= InitHash[i];
      end else begin
         state_ff <= state_in;
         ld_ff    <= ld_in;
         rnd_ff   <= rnd_in;
         oi_ff    <= oi_in;
         end_ff   <= end_in;
         if (state_ff == ST_ADD) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
         end else if (state_ff == ST_OUT && rsp_pop) begin
            // Rotate the state out; the final beat reloads the initial values.
            if (oi_ff == 3'd7) begin
               for (int i = 0; i < 8; i++) h_ff[i] <= InitHash[i];
            end else begin
               for (int i = 0; i < 7; i++) h_ff[i] <= h_ff[i+1];
               h_ff[7] <= h_ff[0];
            end
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (rnd_ff < 7'(Rounds)))
      else $error("round counter overrun");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> (ld_ff == 4'd0))
      else $error("block compressed before fully loaded");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_pop && oi_ff == 3'd7) |=> (h_ff[0] == InitHash[0]))
      else $error("chaining state not reinitialised");

endmodule
`default_nettype wire

@@ src/sha512_stream_hasher_unit.sv @@
`default_nettype none
// SHA-512 streaming hasher.
// Input channel: a message arrives as 64-bit big-endian words on req_data_word,
// one beat per push while req_full is low. req_last_word marks the final word,
// whose req_byte_count (0..8, larger read as 8) gives its valid leading bytes;
// other words always count eight bytes.
// Result channel: after the final word, eight digest words appear one at a
// time while rsp_empty is low, hash word 0 first, rsp_digest_last high on the
// eighth. Each is taken by rsp_pop.
// Timing: the front packs words and generates the padding at one word a cycle,
// unless the four-entry queue is full; the back loads 16 words (one a cycle
// while the queue is not empty) and then runs the 80 compression rounds at one
// a cycle, then an add state folds the result into the chaining state. The
// first digest word appears one or two blocks after the final word, depending
// on whether the padding spills into a second block.
// A stalled result channel holds the back; the queue then fills and req_full
// rises. Reset returns the chaining state to the standard initial values and
// clears the length and block fill; no clearing pass is needed.
module sha512_stream_hasher_unit import shs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [63:0] req_data_word,
   input  wire logic [3:0] req_byte_count,
   input  wire logic       req_last_word,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [63:0]     rsp_digest_word,
   output logic            rsp_digest_last
);

   logic     q_push, q_full, q_pop, q_empty;
   item_type q_in, q_head;

   shs_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data_word, .req_byte_count,
      .req_last_word, .q_push, .q_full, .q_item(q_in)
   );

   shs_queue u_queue (
      .clock, .reset, .push(q_push), .push_item(q_in), .full(q_full),
      .pop(q_pop), .empty(q_empty), .head(q_head)
   );

   shs_back u_back (
      .clock, .reset, .q_empty, .q_head, .q_pop, .rsp_empty, .rsp_pop,
      .rsp_digest_word, .rsp_digest_last
   );

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_digest_word)))
      else $error("result beat changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_digest_last) |=> rsp_empty)
      else $error("result after final digest word");
   assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("reset state wrong");

endmodule
`default_nettype wire

@@ bench/sha512_stream_hasher_unit_tb.sv @@
module sha512_stream_hasher_unit_tb;
   import shs_pkg::*;

   localparam int unsigned WatchdogLimit = 20000;
   localparam int unsigned DrainCycles   = 400;

   typedef struct {
      logic [63:0] data;
      logic [3:0]  count;
      logic        last;
      logic [63:0] first_digest;
      logic        check_first;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [63:0] req_data_word = '0;
   logic [3:0]  req_byte_count = '0;
   logic        req_last_word = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [63:0] rsp_digest_word;
   logic        rsp_digest_last;

   word_type chain_h [8];
   word_type sched_w [16];
   int unsigned words_in_block;
   logic [127:0] msg_bits;

   logic [64:0] digest_queue [$];
   logic [63:0] first_word_known [$];
   logic        first_word_valid [$];
   int unsigned failures = 0;
   int unsigned idle_cycles = 0;
   bit          stimulus_done = 1'b0;
   bit          hold_off = 1'b0;
   bit          hold_done = 1'b0;
   int unsigned digest_index = 0;

   stim_row_type directed_rows [$];

   sha512_stream_hasher_unit i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_data_word(req_data_word), .req_byte_count(req_byte_count),
      .req_last_word(req_last_word),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_digest_word(rsp_digest_word), .rsp_digest_last(rsp_digest_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic word_type ror64(input word_type x, input int unsigned n);
      ror64 = (x >> n) | (x << (64 - n));
   endfunction

   task automatic compress_chain();
      word_type v [8];
      word_type t1, t2, s0, s1, w2, w15;
      for (int j = 0; j < 8; j++) v[j] = chain_h[j];
      for (int t = 0; t < 80; t++) begin
         if (t >= 16) begin
            w2  = sched_w[(t - 2) & 15];
            w15 = sched_w[(t - 15) & 15];
            s1 = ror64(w2, 19) ^ ror64(w2, 61) ^ (w2 >> 6);
            s0 = ror64(w15, 1) ^ ror64(w15, 8) ^ (w15 >> 7);
            sched_w[t & 15] = s1 + sched_w[(t - 7) & 15] + s0 + sched_w[t & 15];
         end
         t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + sched_w[t & 15];
         t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) chain_h[j] += v[j];
   endtask

   task automatic buffer_word(input word_type w);
      sched_w[words_in_block] = w;
      words_in_block++;
      if (words_in_block == 16) begin
         compress_chain();
         words_in_block = 0;
      end
   endtask

   task automatic restart_message();
      for (int j = 0; j < 8; j++) chain_h[j] = InitHash[j];
      msg_bits = '0;
      words_in_block = 0;
   endtask

   // Runs the predictor for one accepted beat and queues any digest words.
   task automatic predict_digest(input logic [63:0] data, input logic [3:0] cnt,
                                 input logic last);
      int unsigned n;
      word_type keep;
      if (!last) begin
         msg_bits += 128'd64;
         buffer_word(data);
      end else begin
         n = (cnt > 8) ? 8 : cnt;
         msg_bits += 128'(n * 8);
         if (n == 8) begin
            buffer_word(data);
            buffer_word(64'h8000000000000000);
         end else begin
            keep = ~({64{1'b1}} >> (8 * n));
            buffer_word((data & keep) | (64'h80 << (56 - 8 * n)));
         end
         if (words_in_block > 14) buffer_word('0);
         while (words_in_block < 14) buffer_word('0);
         buffer_word(msg_bits[127:64]);
         buffer_word(msg_bits[63:0]);
         for (int k = 0; k < 8; k++) digest_queue.push_back({k == 7, chain_h[k]});
         restart_message();
      end
   endtask

   task automatic send_beat(input logic [63:0] data, input logic [3:0] cnt,
                            input logic last, input logic [63:0] known,
                            input logic check_known);
      req_push       <= 1'b1;
      req_data_word  <= data;
      req_byte_count <= cnt;
      req_last_word  <= last;
      do @(posedge clock); while (req_full);
      predict_digest(data, cnt, last);
      if (last) begin
         first_word_known.push_back(known);
         first_word_valid.push_back(check_known);
      end
   endtask

   task automatic idle_gap(input int unsigned n);
      if (n > 0) begin
         req_push <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic [63:0] rand64();
      rand64 = {$urandom, $urandom};
   endfunction

   initial begin
      stim_row_type r;
      int unsigned msg_words, burst, sent;
      // Empty message, and the message "abc": first digest words are well known.
      directed_rows.push_back('{64'h0, 4'd0, 1'b1, 64'hcf83e1357eefb8bd, 1'b1});
      directed_rows.push_back('{64'h6162630000000000, 4'd3, 1'b1,
                                64'hddaf35a193617aba, 1'b1});
      directed_rows.push_back('{'1, 4'd8, 1'b1, '0, 1'b0});
      directed_rows.push_back('{'1, 4'd15, 1'b1, '0, 1'b0});
      directed_rows.push_back('{'1, 4'd9, 1'b1, '0, 1'b0});
      directed_rows.push_back('{'1, 4'd7, 1'b1, '0, 1'b0});
      directed_rows.push_back('{64'h0123456789abcdef, 4'd1, 1'b1, '0, 1'b0});
      // Fourteen words then a full last word spill the padding into a second block.
      for (int i = 0; i < 14; i++)
         directed_rows.push_back('{(i % 2) ? '1 : '0, 4'(i), 1'b0, '0, 1'b0});
      directed_rows.push_back('{64'h5a5a5a5aa5a5a5a5, 4'd8, 1'b1, '0, 1'b0});
      directed_rows.push_back('{'0, 4'd15, 1'b0, '0, 1'b0});
      directed_rows.push_back('{'1, 4'd0, 1'b1, '0, 1'b0});

      restart_message();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         send_beat(r.data, r.count, r.last, r.first_digest, r.check_first);
         if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 4));
      end

      sent = 0;
      burst = 0;
      while (sent < 86) begin
         msg_words = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 33)
                                                 : $urandom_range(0, 5);
         for (int i = 0; i < msg_words; i++) begin
            send_beat(rand64(), 4'($urandom_range(0, 15)), 1'b0, '0, 1'b0);
            sent++;
            if (burst == 0) begin
               idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
               burst = $urandom_range(1, 10);
            end else begin
               burst--;
            end
         end
         send_beat(rand64(), 4'($urandom_range(0, 15)), 1'b1, '0, 1'b0);
         sent++;
      end
      req_push <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Receiver: random stall pattern, with one long hold-off while input piles up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_off) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(0, 3) != 0) || (digest_index % 16 >= 8);
      end
   end

   initial begin
      wait (!reset);
      repeat (300) @(posedge clock);
      hold_off = 1'b1;
      repeat (3000) @(posedge clock);
      hold_off = 1'b0;
      hold_done = 1'b1;
   end

   always @(posedge clock) begin
      logic [64:0] exp_beat;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (digest_queue.size() == 0) begin
            $error("digest beat with nothing expected: %h", rsp_digest_word);
            failures++;
         end else begin
            exp_beat = digest_queue.pop_front();
            if (rsp_digest_word !== exp_beat[63:0]) begin
               $error("digest_word expected %h actual %h", exp_beat[63:0],
                      rsp_digest_word);
               failures++;
            end
            if (rsp_digest_last !== exp_beat[64]) begin
               $error("digest_last expected %b actual %b", exp_beat[64],
                      rsp_digest_last);
               failures++;
            end
            if (digest_index % 8 == 0 && first_word_valid.size() > 0) begin
               if (first_word_valid[0] && rsp_digest_word !== first_word_known[0]) begin
                  $error("digest_word expected %h actual %h", first_word_known[0],
                         rsp_digest_word);
                  failures++;
               end
               void'(first_word_valid.pop_front());
               void'(first_word_known.pop_front());
            end
            digest_index++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || hold_off)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (idle_cycles >= WatchdogLimit) begin
            $display("sha512_stream_hasher_unit_tb NOT OK");
            $finish;
         end
         if (stimulus_done && hold_done && digest_queue.size() == 0) begin
            repeat (DrainCycles) @(posedge clock);
            if (failures == 0 && digest_queue.size() == 0)
               $display("sha512_stream_hasher_unit_tb OK");
            else
               $display("sha512_stream_hasher_unit_tb NOT OK");
            $finish;
         end
      end
   end

endmodule
